// File: hw/rtl/utwbl_pkg.sv
// Shared types, constants and functions for the UTF-8 text width and box layout core.
`default_nettype none
package utwbl_pkg;

    localparam int TOTAL_BITS_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 21;
    localparam int EDGE_W  = 15;
    localparam int AVAIL_W = 14;
    localparam int PAD_W   = 12;
    localparam int TEXT_W  = 16;
    localparam int LEFT_W  = 16;
    localparam int CFG_W   = 15;
    localparam int CFG_AW  = 3;
    localparam int GW_W    = 4;
    localparam int INC_W   = 5;
    localparam int OUT_W   = 48;

    // floor(x / 6) == (x * DIV6_MUL) >> DIV6_SHIFT for every 14-bit x
    localparam int DIV6_SHIFT = 16;
    localparam logic [AVAIL_W-1:0] DIV6_MUL = 14'd10923;

    localparam logic [CODE_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CODE_W-1:0] CP_SPACE    = 21'h000020;

    localparam logic [GW_W-1:0] W_SPACE = 4'd5;
    localparam logic [GW_W-1:0] W_ASCII = 4'd10;
    localparam logic [GW_W-1:0] W_WIDE  = 4'd14;
    localparam logic [GW_W-1:0] W_OTHER = 4'd11;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LEFT_EDGE = 3'd0,
        CFG_AVAIL     = 3'd1,
        CFG_MIN_PAD   = 3'd2,
        CFG_MAX_PAD   = 3'd3,
        CFG_MIN_BOX   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [EDGE_W-1:0]  left_edge;
        logic [AVAIL_W-1:0] avail;
        logic [PAD_W-1:0]   min_pad;
        logic [PAD_W-1:0]   max_pad;
        logic [AVAIL_W-1:0] min_box;
    } t_cfg;

    function automatic logic is_wide(input logic [CODE_W-1:0] cp);
        return (cp >= 21'h001100 && cp <= 21'h0011FF) ||
               (cp >= 21'h002E80 && cp <= 21'h00A4CF) ||
               (cp >= 21'h00AC00 && cp <= 21'h00D7AF) ||
               (cp >= 21'h00F900 && cp <= 21'h00FAFF) ||
               (cp >= 21'h00FE10 && cp <= 21'h00FE6F) ||
               (cp >= 21'h00FF00 && cp <= 21'h00FF60);
    endfunction

    function automatic logic [GW_W-1:0] glyph_width(input logic [CODE_W-1:0] cp);
        logic [GW_W-1:0] w;
        if (cp == CP_SPACE) begin
            w = W_SPACE;
        end else if (cp < 21'h000080) begin
            w = W_ASCII;
        end else if (is_wide(cp)) begin
            w = W_WIDE;
        end else begin
            w = W_OTHER;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/utf8_text_width_box_layout_core.sv
// Top level of the UTF-8 text width estimator with centred box layout.
// Takes one byte of a UTF-8 string per cycle unless a closing byte waits on a full
// result register, and keeps a saturating width total (5 space, 10 other ASCII, 14
// wide CJK/Hangul/fullwidth, 11 else). A request with tlast closes the string: the
// result (text width, box left, box width) goes through the input register, the
// decode/accumulate register and the two layout stages. Items without tlast give no
// result. Configuration is written through a plain write port; the user must write it
// only while no string is in flight, as the block does not enforce it. Control state resets to zero.
`default_nettype none
module utf8_text_width_box_layout_core #(
    parameter int TOTAL_BITS = utwbl_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [utwbl_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [utwbl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] text_byte
    input  wire logic                            s_axis_tuser,  // [0] byte_present
    input  wire logic                            s_axis_tlast,  // last_item
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [15:0] text_width, [31:16] result_left, [45:32] result_width, [47:46] zero
    output logic [utwbl_pkg::OUT_W-1:0]          m_axis_tdata
);

    utwbl_pkg::t_cfg                  r_cfg;
    logic                             r_a_valid;
    logic [utwbl_pkg::BYTE_W-1:0]     r_a_byte;
    logic                             r_a_present;
    logic                             r_a_last;

    logic                             acc_ready, take_a, s_fire;
    logic                             b_valid, c_ready;
    logic [TOTAL_BITS-1:0]            b_total;
    logic [utwbl_pkg::TEXT_W-1:0]     out_text;
    logic [utwbl_pkg::LEFT_W-1:0]     out_left;
    logic [utwbl_pkg::AVAIL_W-1:0]    out_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (utwbl_pkg::t_cfg_idx'(i_cfg_addr))
                utwbl_pkg::CFG_LEFT_EDGE: r_cfg.left_edge <= i_cfg_wdata;
                utwbl_pkg::CFG_AVAIL:     r_cfg.avail     <= i_cfg_wdata[utwbl_pkg::AVAIL_W-1:0];
                utwbl_pkg::CFG_MIN_PAD:   r_cfg.min_pad   <= i_cfg_wdata[utwbl_pkg::PAD_W-1:0];
                utwbl_pkg::CFG_MAX_PAD:   r_cfg.max_pad   <= i_cfg_wdata[utwbl_pkg::PAD_W-1:0];
                utwbl_pkg::CFG_MIN_BOX:   r_cfg.min_box   <= i_cfg_wdata[utwbl_pkg::AVAIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign take_a        = r_a_valid && acc_ready;
    assign s_axis_tready = !r_a_valid || take_a;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_byte    <= s_axis_tdata;
            r_a_present <= s_axis_tuser;
            r_a_last    <= s_axis_tlast;
        end
    end

    utwbl_accum #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_a_valid),
        .i_byte    (r_a_byte),
        .i_present (r_a_present),
        .i_last    (r_a_last),
        .o_ready   (acc_ready),
        .o_valid   (b_valid),
        .o_total   (b_total),
        .i_ready   (c_ready)
    );

    utwbl_layout #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_layout (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (b_valid),
        .i_total      (b_total),
        .o_ready      (c_ready),
        .o_valid      (m_axis_tvalid),
        .o_text_width (out_text),
        .o_left       (out_left),
        .o_width      (out_width),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, out_width, out_left, out_text};

endmodule
`default_nettype wire

// File: hw/rtl/utwbl_accum.sv
// UTF-8 decoder and saturating width accumulator, one byte per cycle unless stalled.
`default_nettype none
module utwbl_accum #(
    parameter int TOTAL_BITS = utwbl_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [utwbl_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic                            i_present,
    input  wire logic                            i_last,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output logic [TOTAL_BITS-1:0]                o_total,
    input  wire logic                            i_ready
);

    logic [1:0]                       r_bp, n_bp;
    logic [utwbl_pkg::CODE_W-1:0]     r_pc, n_pc;
    logic [TOTAL_BITS-1:0]            r_total, n_total;
    logic                             r_valid_b, n_valid_b;
    logic [TOTAL_BITS-1:0]            r_total_b;

    logic                             l_add;
    logic [utwbl_pkg::CODE_W-1:0]     l_code;
    logic [1:0]                       l_bp;
    logic [utwbl_pkg::CODE_W-1:0]     l_pc;

    logic                             c1_v, c2_v;
    logic [utwbl_pkg::CODE_W-1:0]     c1, c2, pc_join;
    logic [utwbl_pkg::INC_W-1:0]      inc;
    logic [TOTAL_BITS:0]              sum;
    logic                             ready_b, fire;

    assign ready_b = !r_valid_b || i_ready;
    assign o_ready = !i_last || ready_b;
    assign fire    = i_valid && o_ready;

    // Lead byte decode
    always_comb begin
        l_add  = 1'b0;
        l_code = '0;
        l_bp   = 2'd0;
        l_pc   = '0;
        if (!i_byte[7]) begin
            l_add  = 1'b1;
            l_code = utwbl_pkg::CODE_W'(i_byte);
        end else if (i_byte[7:5] == 3'b110) begin
            l_bp = 2'd1;
            l_pc = utwbl_pkg::CODE_W'(i_byte[4:0]);
        end else if (i_byte[7:4] == 4'b1110) begin
            l_bp = 2'd2;
            l_pc = utwbl_pkg::CODE_W'(i_byte[3:0]);
        end else if (i_byte[7:3] == 5'b11110) begin
            l_bp = 2'd3;
            l_pc = utwbl_pkg::CODE_W'(i_byte[2:0]);
        end else begin
            l_add  = 1'b1;
            l_code = utwbl_pkg::REPLACEMENT;
        end
    end

    assign pc_join = {r_pc[utwbl_pkg::CODE_W-7:0], i_byte[5:0]};

    always_comb begin
        n_bp = r_bp;
        n_pc = r_pc;
        c1_v = 1'b0;
        c1   = '0;
        c2_v = 1'b0;
        c2   = '0;
        if (i_present) begin
            if (r_bp == 2'd0) begin
                c1_v = l_add;
                c1   = l_code;
                if (!l_add) begin
                    n_bp = l_bp;
                    n_pc = l_pc;
                end
            end else if (i_byte[7:6] == 2'b10) begin
                n_bp = r_bp - 2'd1;
                if (r_bp == 2'd1) begin
                    c1_v = 1'b1;
                    c1   = pc_join;
                    n_pc = '0;
                end else begin
                    n_pc = pc_join;
                end
            end else begin
                // broken sequence: count a replacement, then reuse the byte as a lead
                c1_v = 1'b1;
                c1   = utwbl_pkg::REPLACEMENT;
                c2_v = l_add;
                c2   = l_code;
                n_bp = l_add ? 2'd0 : l_bp;
                n_pc = l_add ? '0 : l_pc;
            end
        end
        // truncated sequence at end of string counts as gathered
        if (i_last && (n_bp != 2'd0)) begin
            c2_v = 1'b1;
            c2   = n_pc;
        end
    end

    always_comb begin
        inc = (c1_v ? utwbl_pkg::INC_W'(utwbl_pkg::glyph_width(c1)) : '0)
            + (c2_v ? utwbl_pkg::INC_W'(utwbl_pkg::glyph_width(c2)) : '0);
        sum = {1'b0, r_total} + (TOTAL_BITS+1)'(inc);
        n_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
    end

    always_comb begin
        n_valid_b = i_ready ? 1'b0 : r_valid_b;
        if (fire && i_last) begin
            n_valid_b = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp      <= 2'd0;
            r_pc      <= '0;
            r_total   <= '0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_b <= n_valid_b;
            if (fire) begin
                if (i_last) begin
                    r_bp    <= 2'd0;
                    r_pc    <= '0;
                    r_total <= '0;
                end else begin
                    r_bp    <= n_bp;
                    r_pc    <= n_pc;
                    r_total <= n_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_last) begin
            r_total_b <= n_total;
        end
    end

    assign o_valid = r_valid_b;
    assign o_total = r_total_b;

endmodule
`default_nettype wire

// File: hw/rtl/utwbl_layout.sv
// Two-stage box layout: padding from spare room, then box width and centred left edge.
`default_nettype none
module utwbl_layout #(
    parameter int TOTAL_BITS = utwbl_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire utwbl_pkg::t_cfg                   i_cfg,
    input  wire logic                              i_valid,
    input  wire logic [TOTAL_BITS-1:0]             i_total,
    output logic                                   o_ready,
    output logic                                   o_valid,
    output logic [utwbl_pkg::TEXT_W-1:0]           o_text_width,
    output logic [utwbl_pkg::LEFT_W-1:0]           o_left,
    output logic [utwbl_pkg::AVAIL_W-1:0]          o_width,
    input  wire logic                              i_ready
);

    localparam int CW = (TOTAL_BITS > utwbl_pkg::AVAIL_W) ? TOTAL_BITS : utwbl_pkg::AVAIL_W;
    localparam int DW = CW + 2;
    localparam int EW = (TOTAL_BITS > utwbl_pkg::TEXT_W) ? TOTAL_BITS : utwbl_pkg::TEXT_W;
    localparam int PW = 2 * utwbl_pkg::AVAIL_W;

    logic                               r_c_valid, r_d_valid;
    logic [TOTAL_BITS-1:0]              r_c_total;
    logic [utwbl_pkg::PAD_W-1:0]        r_c_pad, n_c_pad;
    logic [utwbl_pkg::TEXT_W-1:0]       r_d_text, n_d_text;
    logic [utwbl_pkg::LEFT_W-1:0]       r_d_left, n_d_left;
    logic [utwbl_pkg::AVAIL_W-1:0]      r_d_width, n_d_width;

    logic                               ready_c, ready_d, load_c, load_d;
    logic [CW-1:0]                      est_x, avail_x, room_full;
    logic [utwbl_pkg::AVAIL_W-1:0]      room, spare;
    logic [PW-1:0]                      prod;
    logic [utwbl_pkg::PAD_W-1:0]        pad_raw, pad_hi, pad_lo_clamped;
    logic [DW-1:0]                      desired;
    logic [EW-1:0]                      text_x;

    assign ready_d = !r_d_valid || i_ready;
    assign ready_c = !r_c_valid || ready_d;
    assign o_ready = ready_c;
    assign load_c  = i_valid && ready_c;
    assign load_d  = r_c_valid && ready_d;

    // Stage C: spare room divided by six, clamped
    always_comb begin
        est_x     = CW'(i_total);
        avail_x   = CW'(i_cfg.avail);
        room_full = avail_x - est_x;
        room      = (est_x >= avail_x) ? '0 : room_full[utwbl_pkg::AVAIL_W-1:0];
        prod      = PW'(room) * PW'(utwbl_pkg::DIV6_MUL);
        pad_raw   = prod[utwbl_pkg::DIV6_SHIFT +: utwbl_pkg::PAD_W];
        pad_hi    = (i_cfg.max_pad > i_cfg.min_pad) ? i_cfg.max_pad : i_cfg.min_pad;
        pad_lo_clamped = (pad_raw < i_cfg.min_pad) ? i_cfg.min_pad : pad_raw;
        n_c_pad   = (pad_lo_clamped > pad_hi) ? pad_hi : pad_lo_clamped;
    end

    // Stage D: box width, then centre it in the available bounds; text width saturated
    always_comb begin
        desired = DW'(r_c_total) + DW'({r_c_pad, 1'b0});
        if (desired < DW'(i_cfg.min_box)) begin
            desired = DW'(i_cfg.min_box);
        end
        n_d_width = (desired > DW'(i_cfg.avail)) ? i_cfg.avail
                                                 : desired[utwbl_pkg::AVAIL_W-1:0];
        spare     = i_cfg.avail - n_d_width;
        n_d_left  = {i_cfg.left_edge[utwbl_pkg::EDGE_W-1], i_cfg.left_edge}
                  + utwbl_pkg::LEFT_W'(spare[utwbl_pkg::AVAIL_W-1:1]);
        text_x    = EW'(r_c_total);
        n_d_text  = (text_x > EW'({utwbl_pkg::TEXT_W{1'b1}})) ? '1
                                                               : text_x[utwbl_pkg::TEXT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (ready_c) begin
                r_c_valid <= i_valid;
            end
            if (ready_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_c) begin
            r_c_total <= i_total;
            r_c_pad   <= n_c_pad;
        end
        if (load_d) begin
            r_d_text  <= n_d_text;
            r_d_left  <= n_d_left;
            r_d_width <= n_d_width;
        end
    end

    assign o_valid      = r_d_valid;
    assign o_text_width = r_d_text;
    assign o_left       = r_d_left;
    assign o_width      = r_d_width;

endmodule
`default_nettype wire
